// File: design/ccc_pkg.sv
// Shared types, move tables and ranking helpers for the cube state block.
package ccc_pkg;

  localparam int NumCorners = 8;
  localparam int NumEdges   = 12;
  localparam int NumFaces   = 6;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_MOVE = 1'b1;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_EDGE_MISS   = 3'd1;
  localparam logic [2:0] ST_FLIP_SUM    = 3'd2;
  localparam logic [2:0] ST_CORNER_MISS = 3'd3;
  localparam logic [2:0] ST_TWIST_SUM   = 3'd4;
  localparam logic [2:0] ST_PARITY      = 3'd5;

  typedef struct packed {
    logic        func;
    logic [2:0]  face;
    logic [39:0] corner_word;
    logic [59:0] edge_word;
  } in_t;

  typedef struct packed {
    logic [11:0] twist_coord;
    logic [10:0] flip_coord;
    logic [13:0] slice_coord;
    logic [15:0] corner_rank;
    logic [2:0]  status;
  } out_t;

  typedef logic [7:0][2:0] perm8_t;

  typedef struct packed {
    perm8_t     arr;
    logic [2:0] k;
  } rank_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SRANK,
    S_DONE
  } back_state_t;

  localparam logic [2:0] MV_CP [NumFaces][NumCorners] = '{
    '{3'd3, 3'd0, 3'd1, 3'd2, 3'd4, 3'd5, 3'd6, 3'd7},
    '{3'd4, 3'd1, 3'd2, 3'd0, 3'd7, 3'd5, 3'd6, 3'd3},
    '{3'd1, 3'd5, 3'd2, 3'd3, 3'd0, 3'd4, 3'd6, 3'd7},
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd7, 3'd4},
    '{3'd0, 3'd2, 3'd6, 3'd3, 3'd4, 3'd1, 3'd5, 3'd7},
    '{3'd0, 3'd1, 3'd3, 3'd7, 3'd4, 3'd5, 3'd2, 3'd6}};

  localparam logic [1:0] MV_CO [NumFaces][NumCorners] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
    '{2'd2, 2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd2},
    '{2'd1, 2'd2, 2'd0, 2'd0, 2'd2, 2'd1, 2'd0, 2'd0},
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
    '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd2, 2'd1}};

  localparam logic [3:0] MV_EP [NumFaces][NumEdges] = '{
    '{4'd3, 4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
    '{4'd8, 4'd1, 4'd2, 4'd3, 4'd11, 4'd5, 4'd6, 4'd7, 4'd4, 4'd9, 4'd10, 4'd0},
    '{4'd0, 4'd9, 4'd2, 4'd3, 4'd4, 4'd8, 4'd6, 4'd7, 4'd1, 4'd5, 4'd10, 4'd11},
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd4, 4'd8, 4'd9, 4'd10, 4'd11},
    '{4'd0, 4'd1, 4'd10, 4'd3, 4'd4, 4'd5, 4'd9, 4'd7, 4'd8, 4'd2, 4'd6, 4'd11},
    '{4'd0, 4'd1, 4'd2, 4'd11, 4'd4, 4'd5, 4'd6, 4'd10, 4'd8, 4'd9, 4'd3, 4'd7}};

  localparam logic MV_EO [NumFaces][NumEdges] = '{
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1}};

  // binomial(n, k) for n 0..11, k 1..4 (index k-1)
  localparam logic [8:0] BINOM [NumEdges][4] = '{
    '{9'd0, 9'd0, 9'd0, 9'd0},     '{9'd1, 9'd0, 9'd0, 9'd0},
    '{9'd2, 9'd1, 9'd0, 9'd0},     '{9'd3, 9'd3, 9'd1, 9'd0},
    '{9'd4, 9'd6, 9'd4, 9'd1},     '{9'd5, 9'd10, 9'd10, 9'd5},
    '{9'd6, 9'd15, 9'd20, 9'd15},  '{9'd7, 9'd21, 9'd35, 9'd35},
    '{9'd8, 9'd28, 9'd56, 9'd70},  '{9'd9, 9'd36, 9'd84, 9'd126},
    '{9'd10, 9'd45, 9'd120, 9'd210}, '{9'd11, 9'd55, 9'd165, 9'd330}};

  // One rank step: bring value j to position j by left rotations of a[0..j],
  // k is the number of rotations.
  function automatic rank_t rank_step(perm8_t a, logic [2:0] j);
    logic [2:0] p;
    logic       found;
    logic [3:0] idx;
    rank_t      r;
    p     = '0;
    found = 1'b0;
    for (int m = 0; m < 8; m++) begin
      if (!found && 3'(m) <= j && a[m] == j) begin
        p     = 3'(m);
        found = 1'b1;
      end
    end
    r.arr = a;
    r.k   = '0;
    if (found && p != j) r.k = p + 3'd1;
    if (found) begin
      for (int m = 0; m < 7; m++) begin
        idx = {1'b0, p} + 4'd1 + 4'(m);
        if (idx > {1'b0, j}) idx = idx - ({1'b0, j} + 4'd1);
        if (3'(m) < j) r.arr[m] = a[idx[2:0]];
      end
    end
    return r;
  endfunction

endpackage

// File: design/ccc_front.sv
// Input side: two-entry queue of requests ahead of the evaluation engine.
module ccc_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  ccc_pkg::in_t in_item,
  output logic         q_valid,
  input  logic         q_take,
  output ccc_pkg::in_t q_item
);
  import ccc_pkg::*;

  in_t        mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = mem[rptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop)  rptr <= ~rptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// File: design/ccc_back.sv
// Evaluation engine: cube state, move/load, checks, coordinates, result register.
module ccc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_take,
  input  ccc_pkg::in_t  q_item,
  output logic          empty,
  input  logic          pop,
  output ccc_pkg::out_t out_item
);
  import ccc_pkg::*;

  logic [2:0] cc [NumCorners];
  logic [1:0] ct [NumCorners];
  logic [3:0] ec [NumEdges];
  logic       ef [NumEdges];

  back_state_t state, state_next;
  logic [3:0]  step;
  logic [11:0] tw;
  logic        cpar;
  logic        epar;
  logic [8:0]  sa;
  logic [2:0]  sx;
  perm8_t      e4;
  perm8_t      pc;
  logic [15:0] cr;
  logic [4:0]  sr;
  logic        ovalid;
  out_t        res;

  logic        out_free;
  logic [2:0]  cj;
  rank_t       crs;
  perm8_t      csrc;
  logic [2:0]  sj;
  rank_t       srs;
  logic        cstep_par;
  logic        estep_par;
  logic [3:0]  sidx;
  logic [3:0]  se;
  logic        s_hit;
  logic [15:0] emask;
  logic [7:0]  cmask;
  logic        twist3;
  logic [2:0]  tmod;
  logic [2:0]  st;
  logic [10:0] fcoord;

  assign empty    = !ovalid;
  assign out_item = res;
  assign out_free = !ovalid || pop;
  assign q_take   = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (q_valid) state_next = S_SCAN;
      S_SCAN:  if (step == 4'd11) state_next = S_SRANK;
      S_SRANK: if (step == 4'd2) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Per-step scan logic
  always_comb begin
    cj   = 3'(4'd7 - step);
    csrc = pc;
    if (step == 4'd0) begin
      for (int i = 0; i < NumCorners; i++) csrc[i] = cc[i];
    end
    crs = rank_step(csrc, cj);
    sj  = 3'(4'd3 - step);
    srs = rank_step(e4, sj);
    cstep_par = 1'b0;
    estep_par = 1'b0;
    for (int j = 0; j < NumEdges - 1; j++) begin
      if (4'(j) < step && ec[j] > ec[step]) estep_par = ~estep_par;
    end
    for (int j = 0; j < NumCorners - 1; j++) begin
      if (4'(j) < step && cc[j] > cc[step[2:0]]) cstep_par = ~cstep_par;
    end
    sidx  = 4'd11 - step;
    se    = ec[sidx];
    s_hit = (se >= 4'd8) && (se <= 4'd11) && (sx < 3'd4);
  end

  // Checks over the settled state
  always_comb begin
    emask  = '0;
    cmask  = '0;
    twist3 = 1'b0;
    tmod   = '0;
    for (int i = 0; i < NumEdges; i++) emask[ec[i]] = 1'b1;
    for (int i = 0; i < NumCorners; i++) begin
      cmask[cc[i]] = 1'b1;
      if (ct[i] == 2'd3) twist3 = 1'b1;
      tmod = tmod + {1'b0, ct[i]};
      if (tmod >= 3'd3) tmod = tmod - 3'd3;
    end
    for (int i = 0; i < NumEdges - 1; i++) fcoord[10 - i] = ef[i];
    if (!(&emask[11:0]))                                        st = ST_EDGE_MISS;
    else if (ef[0] ^ ef[1] ^ ef[2] ^ ef[3] ^ ef[4] ^ ef[5] ^
             ef[6] ^ ef[7] ^ ef[8] ^ ef[9] ^ ef[10] ^ ef[11])   st = ST_FLIP_SUM;
    else if (!(&cmask))                                         st = ST_CORNER_MISS;
    else if (twist3 || tmod != 3'd0)                            st = ST_TWIST_SUM;
    else if (cpar ^ epar)                                       st = ST_PARITY;
    else                                                        st = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumCorners; i++) begin
        cc[i] <= 3'(i);
        ct[i] <= 2'd0;
      end
      for (int i = 0; i < NumEdges; i++) begin
        ec[i] <= 4'(i);
        ef[i] <= 1'b0;
      end
      step   <= '0;
      ovalid <= 1'b0;
    end else begin
      if (pop && ovalid && !(state == S_DONE && out_free)) ovalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.func == FUNC_LOAD) begin
              for (int i = 0; i < NumCorners; i++) begin
                cc[i] <= q_item.corner_word[5*i +: 3];
                ct[i] <= q_item.corner_word[5*i+3 +: 2];
              end
              for (int i = 0; i < NumEdges; i++) begin
                ec[i] <= q_item.edge_word[5*i +: 4];
                ef[i] <= q_item.edge_word[5*i+4];
              end
            end else if (q_item.face < 3'(NumFaces)) begin
              for (int i = 0; i < NumCorners; i++) begin
                logic [2:0] s;
                s = {1'b0, ct[MV_CP[q_item.face][i]]} + {1'b0, MV_CO[q_item.face][i]};
                if (s >= 3'd3) s = s - 3'd3;
                cc[i] <= cc[MV_CP[q_item.face][i]];
                ct[i] <= s[1:0];
              end
              for (int i = 0; i < NumEdges; i++) begin
                ec[i] <= ec[MV_EP[q_item.face][i]];
                ef[i] <= ef[MV_EP[q_item.face][i]] ^ MV_EO[q_item.face][i];
              end
            end
            step <= '0;
            tw   <= '0;
            cpar <= 1'b0;
            epar <= 1'b0;
            sa   <= '0;
            sx   <= '0;
            cr   <= '0;
            sr   <= '0;
            for (int i = 0; i < 8; i++) e4[i] <= 3'(i);
          end
        end
        S_SCAN: begin
          epar <= epar ^ estep_par;
          if (step < 4'd8) cpar <= cpar ^ cstep_par;
          if (step < 4'd7) begin
            tw <= 12'(tw * 12'd3) + {10'd0, ct[step[2:0]]};
            pc <= crs.arr;
            cr <= 16'(cr * ({13'd0, cj} + 16'd1)) + {13'd0, crs.k};
          end
          if (s_hit) begin
            sa <= sa + BINOM[step][sx[1:0]];
            e4[3'd3 - {1'b0, sx[1:0]}] <= {1'b0, se[1:0]};
            sx <= sx + 3'd1;
          end
          step <= (step == 4'd11) ? 4'd0 : step + 4'd1;
        end
        S_SRANK: begin
          e4   <= srs.arr;
          sr   <= 5'(sr * ({2'd0, sj} + 5'd1)) + {2'd0, srs.k};
          step <= step + 4'd1;
        end
        S_DONE: begin
          if (out_free) begin
            ovalid     <= 1'b1;
            res.status <= st;
            if (st == ST_OK) begin
              res.twist_coord <= tw;
              res.flip_coord  <= fcoord;
              res.slice_coord <= 14'(sa * 14'd24) + {9'd0, sr};
              res.corner_rank <= cr;
            end else begin
              res.twist_coord <= '0;
              res.flip_coord  <= '0;
              res.slice_coord <= '0;
              res.corner_rank <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: design/cube_cubie_state_and_coordinates.sv
// Top level of the cubie-level cube state and coordinate block.
//
// Usage: requests enter through a queue-style port: drive in_item and raise
// push; the request is taken at a clock edge where push is high and full is
// low. func selects a load of the whole state from corner_word/edge_word or a
// quarter-turn of one face (faces six and seven leave the state unchanged).
// Each request yields exactly one result on out_item, readable while empty is
// low and taken at an edge where pop is high and empty is low.
// A request that reaches the engine passes through its states in order: idle
// applies the load or move, scan walks the edge positions (inversion parity,
// twist digits, slice choice, corner rank steps), slice-rank ranks the
// slice-edge order, and done writes the result register. The engine takes a
// new request only once the last result is written.
// A two-entry input queue holds further requests while the engine works.
// When the receiver stalls, the finished result holds in the output register;
// the engine then waits with its next result, and full rises once the input
// queue fills. Reset (rst, synchronous) returns the cube to solved, empties
// the queue and drops any waiting result.
module cube_cubie_state_and_coordinates (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  ccc_pkg::in_t  in_item,
  output logic          empty,
  input  logic          pop,
  output ccc_pkg::out_t out_item
);
  import ccc_pkg::*;

  logic q_valid;
  logic q_take;
  in_t  q_item;

  // front: hold incoming requests
  ccc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_take  (q_take),
    .q_item  (q_item)
  );

  // back: apply, check, rank, and hold the result
  ccc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_take   (q_take),
    .q_item   (q_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

// File: bench/tb.sv
// Self-checking testbench for the cubie-level cube state and coordinate block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ccc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 60;

  // Face indexes as used by the move tables.
  localparam logic [2:0] FACE_U = 3'd0;
  localparam logic [2:0] FACE_B = 3'd5;

  logic  clk;
  logic  rst;
  logic  push;
  logic  full;
  in_t   in_item;
  logic  empty;
  logic  pop;
  out_t  out_item;

  // Model copy of the cube: cubie numbers and orientations per position.
  logic [2:0] cube_cp [NumCorners];
  logic [1:0] cube_co [NumCorners];
  logic [3:0] cube_ep [NumEdges];
  logic       cube_eo [NumEdges];

  out_t        coord_q [$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  logic        pop_hold;

  cube_cubie_state_and_coordinates u_top (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Return a gap length: mostly zero or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Rank a permutation by left rotations; the value n-1+base moves into the
  // last place first, counting rotations as a mixed-radix digit.
  function automatic int unsigned rotate_rank(int a[], int n, int base);
    int unsigned b;
    int unsigned k;
    int          t;
    b = 0;
    for (int j = n - 1; j > 0; j--) begin
      k = 0;
      while (a[j] != j + base && k <= j) begin
        t = a[0];
        for (int i = 0; i < j; i++) a[i] = a[i + 1];
        a[j] = t;
        k++;
      end
      b = (j + 1) * b + k;
    end
    return b;
  endfunction

  // Validity check of the current cube; the first failing check wins.
  function automatic logic [2:0] cube_status();
    int cnt [16];
    int sum;
    int inv_c;
    int inv_e;
    foreach (cnt[i]) cnt[i] = 0;
    for (int i = 0; i < NumEdges; i++) cnt[cube_ep[i]]++;
    for (int i = 0; i < NumEdges; i++) if (cnt[i] != 1) return ST_EDGE_MISS;
    sum = 0;
    for (int i = 0; i < NumEdges; i++) sum += cube_eo[i];
    if (sum % 2 != 0) return ST_FLIP_SUM;
    foreach (cnt[i]) cnt[i] = 0;
    for (int i = 0; i < NumCorners; i++) cnt[cube_cp[i]]++;
    for (int i = 0; i < NumCorners; i++) if (cnt[i] != 1) return ST_CORNER_MISS;
    sum = 0;
    for (int i = 0; i < NumCorners; i++) begin
      if (cube_co[i] >= 3) return ST_TWIST_SUM;
      sum += cube_co[i];
    end
    if (sum % 3 != 0) return ST_TWIST_SUM;
    inv_c = 0;
    for (int i = 1; i < NumCorners; i++)
      for (int j = 0; j < i; j++) if (cube_cp[j] > cube_cp[i]) inv_c++;
    inv_e = 0;
    for (int i = 1; i < NumEdges; i++)
      for (int j = 0; j < i; j++) if (cube_ep[j] > cube_ep[i]) inv_e++;
    if (((inv_c ^ inv_e) & 1) != 0) return ST_PARITY;
    return ST_OK;
  endfunction

  // Apply one request to the model cube and return the coordinates it yields.
  function automatic out_t cube_apply(in_t req);
    out_t        res;
    logic [2:0]  ncp [NumCorners];
    logic [1:0]  nco [NumCorners];
    logic [3:0]  nep [NumEdges];
    logic        neo [NumEdges];
    int          src;
    int          e4[];
    int          pc[];
    int          x;
    int unsigned a;
    int unsigned tw;
    int unsigned fl;
    if (req.func == FUNC_LOAD) begin
      for (int i = 0; i < NumCorners; i++) begin
        cube_cp[i] = req.corner_word[5*i +: 3];
        cube_co[i] = req.corner_word[5*i+3 +: 2];
      end
      for (int i = 0; i < NumEdges; i++) begin
        cube_ep[i] = req.edge_word[5*i +: 4];
        cube_eo[i] = req.edge_word[5*i+4];
      end
    end else if (req.face < NumFaces) begin
      for (int i = 0; i < NumCorners; i++) begin
        src    = MV_CP[req.face][i];
        ncp[i] = cube_cp[src];
        nco[i] = 2'((cube_co[src] + MV_CO[req.face][i]) % 3);
      end
      for (int i = 0; i < NumEdges; i++) begin
        src    = MV_EP[req.face][i];
        nep[i] = cube_ep[src];
        neo[i] = cube_eo[src] ^ MV_EO[req.face][i];
      end
      cube_cp = ncp;
      cube_co = nco;
      cube_ep = nep;
      cube_eo = neo;
    end
    res        = '0;
    res.status = cube_status();
    if (res.status == ST_OK) begin
      tw = 0;
      for (int i = 0; i < NumCorners - 1; i++) tw = 3 * tw + cube_co[i];
      fl = 0;
      for (int i = 0; i < NumEdges - 1; i++) fl = 2 * fl + cube_eo[i];
      e4 = new[4];
      x  = 0;
      a  = 0;
      for (int j = NumEdges - 1; j >= 0; j--) begin
        if (cube_ep[j] >= 8 && cube_ep[j] <= 11 && x < 4) begin
          // C(11-j, x+1); BINOM row n holds k=1..4.
          a += BINOM[11 - j][x];
          e4[3 - x] = cube_ep[j];
          x++;
        end
      end
      pc = new[8];
      for (int i = 0; i < NumCorners; i++) pc[i] = cube_cp[i];
      res.twist_coord = 12'(tw);
      res.flip_coord  = 11'(fl);
      res.slice_coord = 14'(24 * a + rotate_rank(e4, 4, 8));
      res.corner_rank = 16'(rotate_rank(pc, 8, 0));
    end
    return res;
  endfunction

  // Send one request and queue its expected coordinates once it is taken.
  // Push stays high after the accepting edge; a gap or a drain drops it.
  task automatic send_req(in_t req);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      push    <= 1'b0;
      in_item <= in_t'({$urandom(), $urandom(), $urandom(), $urandom()});
      repeat (g) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (full) @(posedge clk);
    coord_q.push_back(cube_apply(req));
  endtask

  function automatic in_t mk_move(logic [2:0] face);
    in_t r;
    r = in_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    r.func = FUNC_MOVE;
    r.face = face;
    return r;
  endfunction

  // Load request built from per-position cubies and orientations.
  function automatic in_t mk_load(int cp[8], int co[8], int ep[12], int eo[12]);
    in_t r;
    r = in_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    r.func = FUNC_LOAD;
    for (int i = 0; i < 8; i++) r.corner_word[5*i +: 5] = {2'(co[i]), 3'(cp[i])};
    for (int i = 0; i < 12; i++) r.edge_word[5*i +: 5] = {1'(eo[i]), 4'(ep[i])};
    return r;
  endfunction

  // Load a random legal cube, with an optional single defect.
  function automatic in_t mk_legal(int defect);
    int cp[8];
    int co[8];
    int ep[12];
    int eo[12];
    int s;
    int t;
    int p;
    int q;
    int sw;
    for (int i = 0; i < 8; i++) cp[i] = i;
    for (int i = 0; i < 12; i++) ep[i] = i;
    sw = 0;
    for (int i = 7; i > 0; i--) begin
      p = $urandom_range(0, i);
      if (p != i) sw ^= 1;
      t = cp[i]; cp[i] = cp[p]; cp[p] = t;
    end
    for (int i = 11; i > 0; i--) begin
      p = $urandom_range(0, i);
      if (p != i) sw ^= 1;
      t = ep[i]; ep[i] = ep[p]; ep[p] = t;
    end
    if (sw) begin
      t = ep[0]; ep[0] = ep[1]; ep[1] = t;
    end
    s = 0;
    for (int i = 0; i < 7; i++) begin co[i] = $urandom_range(0, 2); s += co[i]; end
    co[7] = (3 - s % 3) % 3;
    s = 0;
    for (int i = 0; i < 11; i++) begin eo[i] = $urandom_range(0, 1); s += eo[i]; end
    eo[11] = s % 2;
    p = $urandom_range(0, 11);
    q = $urandom_range(0, 7);
    case (defect)
      1: ep[p] = (p == 0) ? $urandom_range(12, 15) : ep[(p + 1) % 12];
      2: eo[p] ^= 1;
      3: cp[q] = cp[(q + 1) % 8];
      4: co[q] = (co[q] + 1) % 3;
      5: begin t = ep[0]; ep[0] = ep[1]; ep[1] = t; end
      6: co[q] = 3;
      default: ;
    endcase
    return mk_load(cp, co, ep, eo);
  endfunction

  // Drop push, then wait until every queued result has been collected.
  task automatic wait_drained();
    push    <= 1'b0;
    in_item <= in_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    @(posedge clk);
    while (coord_q.size() != 0) @(posedge clk);
  endtask

  // Directed: every face in turn from solved, unused faces, extremes and each defect.
  task automatic test_directed();
    int cp[8];
    int co[8];
    int ep[12];
    int eo[12];
    for (int f = FACE_U; f <= FACE_B; f++) send_req(mk_move(3'(f)));
    send_req(mk_move(3'd6));
    send_req(mk_move(3'd7));
    send_req(in_t'({FUNC_LOAD, 3'd7, {40{1'b1}}, {60{1'b1}}}));
    send_req(in_t'({FUNC_LOAD, 3'd0, 40'd0, 60'd0}));
    for (int d = 0; d <= 6; d++) send_req(mk_legal(d));
    // Twist of three everywhere on a legal permutation, then a move folds it.
    for (int i = 0; i < 8; i++) begin cp[i] = i; co[i] = 3; end
    for (int i = 0; i < 12; i++) begin ep[i] = i; eo[i] = 1; end
    send_req(mk_load(cp, co, ep, eo));
    send_req(mk_move(FACE_U));
    // Edge cubie above eleven survives a move that carries it.
    ep[0] = 15;
    send_req(mk_load(cp, co, ep, eo));
    send_req(mk_move(3'd1));
    wait_drained();
  endtask

  // Random: mostly moves, with legal loads, defective loads and some noise loads.
  task automatic test_random();
    int n;
    int r;
    in_t req;
    n = 0;
    while (n < 400) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        req = in_t'({$urandom(), $urandom(), $urandom(), $urandom()});
        req.func = FUNC_LOAD;
      end else if (r < 25) begin
        req = mk_legal($urandom_range(1, 6));
      end else if (r < 35) begin
        req = mk_legal(0);
      end else begin
        req = mk_move(3'($urandom_range(0, 7)));
      end
      send_req(req);
      n++;
      if (n == 200) wait_drained();
    end
  endtask

  // Compare each collected result with the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (!rst && pop && !empty) begin
      if (coord_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %p", out_item);
      end else begin
        want = coord_q.pop_front();
        if (out_item !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp tw=%0d fl=%0d sl=%0d cr=%0d st=%0d got tw=%0d fl=%0d sl=%0d cr=%0d st=%0d",
                     want.twist_coord, want.flip_coord, want.slice_coord,
                     want.corner_rank, want.status, out_item.twist_coord,
                     out_item.flip_coord, out_item.slice_coord,
                     out_item.corner_rank, out_item.status);
        end
      end
    end
  end

  // Receiver: random pop stalls, short mostly, occasionally long.
  always @(posedge clk) begin
    int unsigned g;
    if (rst) begin
      pop      <= 1'b0;
      pop_hold <= 1'b0;
    end else if (!pop_hold) begin
      pop_hold <= 1'b1;
      g = gap_len();
      pop <= (g == 0);
      fork
        begin
          if (g != 0) begin
            repeat (g) @(posedge clk);
            pop <= 1'b1;
          end
          repeat ($urandom_range(1, 12)) @(posedge clk);
          pop_hold <= 1'b0;
        end
      join_none
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    push         = 1'b0;
    in_item      = '0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    for (int i = 0; i < NumCorners; i++) begin cube_cp[i] = 3'(i); cube_co[i] = '0; end
    for (int i = 0; i < NumEdges; i++) begin cube_ep[i] = 4'(i); cube_eo[i] = 1'b0; end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    wait_drained();
    repeat (DrainWait) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
